// File: hw/rtl/decaying_peer_score_table_assert.svh
// Assertion macros shared by the peer score table modules.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef DECAYING_PEER_SCORE_TABLE_ASSERT_SVH
`define DECAYING_PEER_SCORE_TABLE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication
`define DPST_ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dpst assertion failed");
// Next-cycle implication
`define DPST_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dpst assertion failed");
`else
`define DPST_ASSERT_IMPLY(label, clk, rst, cond, cons)
`define DPST_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

// File: hw/rtl/dpst_pkg.sv
`timescale 1ns / 1ps

package dpst_pkg;

  // Table geometry
  localparam int PEER_COUNT      = 64;
  localparam int PEER_W          = $clog2(PEER_COUNT);
  localparam int PEER_FIELD_W    = 6;
  localparam int FRAC_TABLE_BITS = 8;
  localparam int CNT_W           = $clog2(FRAC_TABLE_BITS);

  // Score format: unsigned, 16 fraction bits, 1.0 is the largest value
  localparam int SCORE_W = 17;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 32;
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(65536);

  // Shifts at or beyond this clear any score
  localparam int SHIFT_LIMIT = SCORE_W + 1;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_THRESHOLD = 2'd2;

  localparam logic [RATE_W-1:0]  DECAY_RATE_RESET        = RATE_W'(279728);
  localparam logic [SCORE_W-1:0] PRUNE_THRESHOLD_RESET   = SCORE_W'(19661);
  localparam logic [SCORE_W-1:0] FORWARD_THRESHOLD_RESET = SCORE_W'(26214);

  typedef enum logic [1:0] {
    CMD_REWARD   = 2'd0,
    CMD_PENALIZE = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_t;

  // One table entry
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  touch;
  } entry_t;

  // Root table: entry j is floor(2^32 * 2^-(2^-(j+1)))
  typedef logic [31:0] root_tab_t [FRAC_TABLE_BITS];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    v = x;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] v;
    v = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 0; j < FRAC_TABLE_BITS; j++) begin
      t[j] = v[31:0];
      v = isqrt64(v << 32);
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TABLE = build_roots();

endpackage

// File: hw/rtl/decaying_peer_score_table.sv
`timescale 1ns / 1ps

// Peer score table with lazy exponential decay.
// Request channel (req_valid / req_stall): command, peer, amount, now. A word
// is taken at an edge with req_valid high and req_stall low. Response channel
// (rsp_valid / rsp_stall): score_after, known, forward_ok, prune, one word per
// request, in order. Config channel (cfg_valid / cfg_ready, ready always high):
// cfg_index selects the decay rate, the prune limit or the forward limit;
// other indexes are ignored. Write config only while the block is idle.
// One request is in flight at a time. From acceptance a request passes the
// read, decay and finish states, and the output register then raises rsp_valid;
// a new request is taken only once the block is back in idle. The decay unit
// takes one fraction bit per cycle on its shared root multiplier.
// The result waits in an output register, so the next request is taken while
// rsp_stall holds the previous response; a second response waits in the
// write-back state until the first leaves.
// Reset clears all known bits (every peer unknown) and loads the default
// thresholds and decay rate. No clearing pass is needed.
module decaying_peer_score_table (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [1:0]                            command,
  input  logic [dpst_pkg::PEER_FIELD_W-1:0]     peer,
  input  logic [dpst_pkg::SCORE_W-1:0]          amount,
  input  logic [dpst_pkg::TIME_W-1:0]           now,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [dpst_pkg::SCORE_W-1:0]          score_after,
  output logic                                  known,
  output logic                                  forward_ok,
  output logic                                  prune,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dpst_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_data
);

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_READ   = 4'b0010,
    T_DECAY  = 4'b0100,
    T_FINISH = 4'b1000
  } tstate_t;

  tstate_t state;

  // configuration
  logic [dpst_pkg::RATE_W-1:0]  decay_rate;
  logic [dpst_pkg::SCORE_W-1:0] prune_limit;
  logic [dpst_pkg::SCORE_W-1:0] forward_limit;

  // latched request
  dpst_pkg::cmd_t               cmd_r;
  logic [dpst_pkg::PEER_W-1:0]  idx_r;
  logic [dpst_pkg::SCORE_W-1:0] amount_r;
  logic [dpst_pkg::TIME_W-1:0]  now_r;
  logic                         known_r;
  logic                         in_range_r;

  // storage
  dpst_pkg::entry_t             entry_mem [dpst_pkg::PEER_COUNT];
  dpst_pkg::entry_t             rd_data;
  logic [dpst_pkg::PEER_COUNT-1:0] known_bits;

  logic                         req_take;
  logic                         rsp_take;
  logic [dpst_pkg::PEER_W-1:0]  peer_idx;
  logic                         peer_in_range;

  logic                         dec_start;
  logic                         dec_done;
  logic [dpst_pkg::SCORE_W-1:0] dec_score;
  logic [dpst_pkg::SCORE_W-1:0] stored_score;
  logic [dpst_pkg::TIME_W-1:0]  elapsed;

  logic                         finish_go;
  logic                         wr_en;
  logic [dpst_pkg::SCORE_W:0]   sum;
  logic [dpst_pkg::SCORE_W-1:0] result;
  logic                         fwd;
  logic                         prn;

  assign req_stall     = (state != T_IDLE);
  assign req_take      = req_valid && !req_stall;
  assign rsp_take      = rsp_valid && !rsp_stall;
  assign cfg_ready     = 1'b1;
  assign peer_idx      = dpst_pkg::PEER_W'(peer);
  assign peer_in_range = 32'(peer) < 32'(dpst_pkg::PEER_COUNT);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate    <= dpst_pkg::DECAY_RATE_RESET;
      prune_limit   <= dpst_pkg::PRUNE_THRESHOLD_RESET;
      forward_limit <= dpst_pkg::FORWARD_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpst_pkg::REG_DECAY_RATE:        decay_rate    <= cfg_data;
        dpst_pkg::REG_PRUNE_THRESHOLD:   prune_limit   <= cfg_data[dpst_pkg::SCORE_W-1:0];
        dpst_pkg::REG_FORWARD_THRESHOLD: forward_limit <= cfg_data[dpst_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE:   if (req_take) state <= T_READ;
        T_READ:   state <= T_DECAY;
        T_DECAY:  if (dec_done) state <= T_FINISH;
        T_FINISH: if (finish_go) state <= T_IDLE;
        default:  state <= T_IDLE;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_r      <= dpst_pkg::cmd_t'(command);
      idx_r      <= peer_idx;
      amount_r   <= amount;
      now_r      <= now;
      in_range_r <= peer_in_range;
      known_r    <= peer_in_range && known_bits[peer_idx];
    end
  end

  // entry memory: read on accept, write back in the finish state
  always_ff @(posedge clk) begin
    if (req_take) rd_data <= entry_mem[peer_idx];
    if (wr_en) entry_mem[idx_r] <= '{score: result, touch: now_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known_bits <= '0;
    end else if (wr_en) begin
      known_bits[idx_r] <= 1'b1;
    end
  end

  // decay launch; a time that runs backwards or an unknown peer gives zero elapsed
  assign dec_start    = (state == T_READ);
  assign stored_score = known_r ? rd_data.score : '0;
  assign elapsed      = (known_r && (now_r > rd_data.touch)) ? now_r - rd_data.touch : '0;

  dpst_decay u_decay (
    .clk     (clk),
    .rst     (rst),
    .start   (dec_start),
    .score   (stored_score),
    .elapsed (elapsed),
    .rate    (decay_rate),
    .done    (dec_done),
    .decayed (dec_score)
  );

  // command results
  assign sum = {1'b0, dec_score} + {1'b0, amount_r};

  always_comb begin
    result = '0;
    fwd    = 1'b0;
    prn    = 1'b0;
    case (cmd_r)
      dpst_pkg::CMD_REWARD: begin
        result = (sum > {1'b0, dpst_pkg::SCORE_ONE}) ? dpst_pkg::SCORE_ONE
                                                    : sum[dpst_pkg::SCORE_W-1:0];
      end
      dpst_pkg::CMD_PENALIZE: begin
        result = (dec_score > amount_r) ? dec_score - amount_r : '0;
        prn    = result < prune_limit;
      end
      dpst_pkg::CMD_QUERY: begin
        result = dec_score;
        fwd    = known_r && (dec_score > forward_limit);
      end
      dpst_pkg::CMD_LOAD: begin
        result = (amount_r > dpst_pkg::SCORE_ONE) ? dpst_pkg::SCORE_ONE : amount_r;
      end
      default: ;
    endcase
  end

  assign finish_go = (state == T_FINISH) && (!rsp_valid || !rsp_stall);
  assign wr_en     = finish_go && in_range_r && (cmd_r != dpst_pkg::CMD_QUERY);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      score_after <= in_range_r ? result : '0;
      known       <= known_r;
      forward_ok  <= in_range_r && fwd;
      prune       <= in_range_r && prn;
    end
  end

  `include "decaying_peer_score_table_assert.svh"

  `DPST_ASSERT_IMPLY(a_done_in_decay, clk, rst, dec_done, state == T_DECAY)
  `DPST_ASSERT_NEXT(a_hold_finish, clk, rst, state == T_FINISH && !finish_go, state == T_FINISH)
  `DPST_ASSERT_IMPLY(a_score_bound, clk, rst, rsp_valid, score_after <= dpst_pkg::SCORE_ONE)
  `DPST_ASSERT_IMPLY(a_flags_exclusive, clk, rst, rsp_valid, !(forward_ok && prune))

endmodule

// File: hw/rtl/dpst_decay.sv
`timescale 1ns / 1ps

// Decay unit: decayed = ((score * prod(roots)) >> 32) >> q, one root per cycle.
module dpst_decay (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dpst_pkg::SCORE_W-1:0]  score,
  input  logic [dpst_pkg::TIME_W-1:0]   elapsed,
  input  logic [dpst_pkg::RATE_W-1:0]   rate,
  output logic                          done,
  output logic [dpst_pkg::SCORE_W-1:0]  decayed
);

  typedef enum logic [3:0] {
    U_IDLE  = 4'b0001,
    U_ROOT  = 4'b0010,
    U_SCALE = 4'b0100,
    U_SHIFT = 4'b1000
  } ustate_t;

  ustate_t u_state;

  logic [31:0]                              e_int;
  logic [dpst_pkg::FRAC_TABLE_BITS-1:0]     frac_sh;
  logic [dpst_pkg::CNT_W-1:0]               cnt;
  logic [31:0]                              m;
  logic                                     m_one;
  logic [dpst_pkg::SCORE_W-1:0]             score_r;
  logic [dpst_pkg::SCORE_W+31:0]            prod;

  logic [63:0] e_full;
  logic [63:0] root_mul;
  logic [31:0] root_now;

  assign e_full   = 64'(elapsed) * 64'(rate);
  assign root_now = dpst_pkg::ROOT_TABLE[cnt];
  assign root_mul = 64'(m) * 64'(root_now);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      u_state <= U_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (u_state)
        U_IDLE: begin
          if (start) u_state <= U_ROOT;
        end
        U_ROOT: begin
          if (cnt == dpst_pkg::CNT_W'(dpst_pkg::FRAC_TABLE_BITS - 1)) u_state <= U_SCALE;
        end
        U_SCALE: u_state <= U_SHIFT;
        U_SHIFT: begin
          done    <= 1'b1;
          u_state <= U_IDLE;
        end
        default: u_state <= U_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (u_state)
      U_IDLE: begin
        if (start) begin
          e_int   <= e_full[63:32];
          frac_sh <= e_full[31 -: dpst_pkg::FRAC_TABLE_BITS];
          score_r <= score;
          cnt     <= '0;
          m_one   <= 1'b1;
        end
      end
      U_ROOT: begin
        // one fraction bit per cycle, most significant first
        if (frac_sh[dpst_pkg::FRAC_TABLE_BITS-1]) begin
          m     <= m_one ? root_now : root_mul[63:32];
          m_one <= 1'b0;
        end
        frac_sh <= frac_sh << 1;
        cnt     <= cnt + dpst_pkg::CNT_W'(1);
      end
      U_SCALE: begin
        prod <= m_one ? {score_r, 32'd0}
                      : (dpst_pkg::SCORE_W + 32)'(score_r) * (dpst_pkg::SCORE_W + 32)'(m);
      end
      U_SHIFT: begin
        if (e_int >= 32'(dpst_pkg::SHIFT_LIMIT)) begin
          decayed <= '0;
        end else begin
          decayed <= prod[dpst_pkg::SCORE_W+31:32] >> e_int[4:0];
        end
      end
      default: ;
    endcase
  end

  `include "decaying_peer_score_table_assert.svh"

  `DPST_ASSERT_IMPLY(a_start_idle, clk, rst, start, u_state == U_IDLE)
  `DPST_ASSERT_NEXT(a_scale_shift, clk, rst, u_state == U_SCALE, u_state == U_SHIFT)
  `DPST_ASSERT_IMPLY(a_no_growth, clk, rst, done, decayed <= score_r)

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  // Unnamed index that the block must ignore
  localparam logic [dpst_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    dpst_pkg::cmd_t                         cmd;
    logic [dpst_pkg::PEER_FIELD_W-1:0]      peer;
    logic [dpst_pkg::SCORE_W-1:0]           amount;
    logic [dpst_pkg::TIME_W-1:0]            now;
  } score_req_t;

  typedef struct packed {
    logic [dpst_pkg::SCORE_W-1:0] score;
    logic                         known;
    logic                         fwd;
    logic                         prune;
  } score_rsp_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  logic [1:0]                          command = 2'd0;
  logic [dpst_pkg::PEER_FIELD_W-1:0]   peer = '0;
  logic [dpst_pkg::SCORE_W-1:0]        amount = '0;
  logic [dpst_pkg::TIME_W-1:0]         now = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b0;
  logic [dpst_pkg::SCORE_W-1:0]        score_after;
  logic                                known;
  logic                                forward_ok;
  logic                                prune;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [dpst_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [31:0]                         cfg_data = '0;

  // Shadow copy of the table and its registers
  logic [dpst_pkg::SCORE_W-1:0] shadow_score [dpst_pkg::PEER_COUNT];
  logic [dpst_pkg::TIME_W-1:0]  peer_touch [dpst_pkg::PEER_COUNT];
  logic                         peer_known [dpst_pkg::PEER_COUNT];
  logic [dpst_pkg::RATE_W-1:0]  rate_reg;
  logic [dpst_pkg::SCORE_W-1:0] prune_thr;
  logic [dpst_pkg::SCORE_W-1:0] fwd_thr;
  logic [31:0]                  root_factor [dpst_pkg::FRAC_TABLE_BITS];

  score_req_t score_req_q [$];
  score_rsp_t expected_scores [$];
  score_req_t next_word;
  score_rsp_t want;

  int words_sent = 0;
  int words_taken = 0;
  int rsp_checked = 0;
  int cfg_writes = 0;
  int failures = 0;
  int mismatches = 0;
  int cmd_hits [4] = '{0, 0, 0, 0};
  int gap_pct = 29;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [dpst_pkg::TIME_W-1:0] t_now = '0;

  decaying_peer_score_table DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .command(command), .peer(peer), .amount(amount), .now(now),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .score_after(score_after), .known(known), .forward_ok(forward_ok), .prune(prune),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Lazy decay: 2^-(elapsed*rate) as a shift plus a product of roots
  function automatic logic [dpst_pkg::SCORE_W-1:0] decay_score(
      logic [dpst_pkg::SCORE_W-1:0] s,
      logic [dpst_pkg::TIME_W-1:0]  last,
      logic [dpst_pkg::TIME_W-1:0]  t);
    logic [63:0] prod;
    logic [63:0] m;
    logic [63:0] scaled;
    logic [31:0] whole;
    logic [dpst_pkg::FRAC_TABLE_BITS-1:0] frac;
    if (t <= last) return s;
    prod = 64'(t - last) * 64'(rate_reg);
    whole = prod[63:32];
    if (whole >= 18) return '0;
    frac = prod[31:32-dpst_pkg::FRAC_TABLE_BITS];
    m = 64'd1 << 32;
    for (int j = 0; j < dpst_pkg::FRAC_TABLE_BITS; j++)
      if (frac[dpst_pkg::FRAC_TABLE_BITS-1-j]) m = (m * 64'(root_factor[j])) >> 32;
    scaled = (64'(s) * m) >> 32;
    return dpst_pkg::SCORE_W'(scaled >> whole);
  endfunction

  // Apply one command to the shadow table and return the response word
  function automatic score_rsp_t apply_score_op(score_req_t w);
    score_rsp_t r;
    logic [dpst_pkg::SCORE_W-1:0] base;
    logic [dpst_pkg::SCORE_W:0] sum;
    r = '0;
    r.known = peer_known[w.peer];
    base = r.known ? decay_score(shadow_score[w.peer], peer_touch[w.peer], w.now) : '0;
    case (w.cmd)
      dpst_pkg::CMD_REWARD: begin
        sum = (dpst_pkg::SCORE_W+1)'(base) + (dpst_pkg::SCORE_W+1)'(w.amount);
        r.score = (sum > dpst_pkg::SCORE_ONE) ? dpst_pkg::SCORE_ONE
                                              : sum[dpst_pkg::SCORE_W-1:0];
      end
      dpst_pkg::CMD_PENALIZE: begin
        r.score = (base > w.amount) ? base - w.amount : '0;
        r.prune = r.score < prune_thr;
      end
      dpst_pkg::CMD_QUERY: begin
        r.score = base;
        r.fwd = r.known && (base > fwd_thr);
      end
      default: begin
        r.score = (w.amount > dpst_pkg::SCORE_ONE) ? dpst_pkg::SCORE_ONE : w.amount;
      end
    endcase
    if (w.cmd != dpst_pkg::CMD_QUERY) begin
      shadow_score[w.peer] = r.score;
      peer_touch[w.peer] = w.now;
      peer_known[w.peer] = 1'b1;
    end
    return r;
  endfunction

  // Request driver: hold a word until taken, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && words_taken != words_sent) begin
      req_valid <= 1'b1;
    end else if (score_req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
      next_word = score_req_q.pop_front();
      req_valid <= 1'b1;
      command <= next_word.cmd;
      peer <= next_word.peer;
      amount <= next_word.amount;
      now <= next_word.now;
      words_sent++;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Response back-pressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  // Monitor: track config writes, predict on request, check on response
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dpst_pkg::REG_DECAY_RATE:        rate_reg <= cfg_data;
          dpst_pkg::REG_PRUNE_THRESHOLD:   prune_thr <= cfg_data[dpst_pkg::SCORE_W-1:0];
          dpst_pkg::REG_FORWARD_THRESHOLD: fwd_thr <= cfg_data[dpst_pkg::SCORE_W-1:0];
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_checked <= rsp_checked + 1;
        if (expected_scores.size() == 0) begin
          failures <= failures + 1;
          $display("response word with nothing outstanding: score %0d", score_after);
        end else begin
          want = expected_scores.pop_front();
          if (score_after !== want.score || known !== want.known ||
              forward_ok !== want.fwd || prune !== want.prune) begin
            failures <= failures + 1;
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: want %0d %0b %0b %0b, got %0d %0b %0b %0b",
                       want.score, want.known, want.fwd, want.prune,
                       score_after, known, forward_ok, prune);
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_scores.push_back(apply_score_op(
            score_req_t'{dpst_pkg::cmd_t'(command), peer, amount, now}));
        cmd_hits[command] <= cmd_hits[command] + 1;
        words_taken <= words_taken + 1;
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("decaying_peer_score_table verification failed");
      $finish;
    end
  end

  task automatic push_word(dpst_pkg::cmd_t c, logic [dpst_pkg::PEER_FIELD_W-1:0] p,
                           logic [dpst_pkg::SCORE_W-1:0] a, logic [dpst_pkg::TIME_W-1:0] t);
    score_req_q.push_back(score_req_t'{c, p, a, t});
  endtask

  // Writes all three registers plus the unused index, valid held high throughout
  task automatic program_regs(logic [dpst_pkg::RATE_W-1:0] rate,
                              logic [dpst_pkg::SCORE_W-1:0] prn,
                              logic [dpst_pkg::SCORE_W-1:0] fwd);
    logic [dpst_pkg::CFG_IDX_W-1:0] idx [4];
    logic [31:0] vals [4];
    int seen;
    idx = '{dpst_pkg::REG_DECAY_RATE, dpst_pkg::REG_PRUNE_THRESHOLD,
            dpst_pkg::REG_FORWARD_THRESHOLD, REG_UNUSED};
    vals = '{rate, 32'(prn), 32'(fwd), $urandom};
    for (int i = 0; i < 4; i++) begin
      seen = cfg_writes;
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(negedge clk);
      while (cfg_writes == seen) @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued word has been sent and answered
  task automatic drain();
    while (score_req_q.size() != 0 || words_sent != words_taken || expected_scores.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Random words: few peers so entries get revisited, time mostly moving forward
  task automatic queue_random(int n);
    score_req_t w;
    int r;
    for (int i = 0; i < n; i++) begin
      w.cmd = dpst_pkg::cmd_t'($urandom_range(3));
      w.peer = ($urandom_range(3) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      r = $urandom_range(99);
      if (r < 70) t_now += 32'($urandom_range(600));
      else if (r < 85) t_now += 32'($urandom_range(20000));
      else if (r < 92) t_now -= 32'($urandom_range(500));
      else if (r < 97) t_now = $urandom;
      w.now = t_now;
      r = $urandom_range(99);
      if (r < 75) w.amount = dpst_pkg::SCORE_W'($urandom_range(30000));
      else if (r < 90) w.amount = dpst_pkg::SCORE_W'($urandom_range(131071));
      else if (r < 94) w.amount = '0;
      else if (r < 97) w.amount = dpst_pkg::SCORE_ONE;
      else w.amount = '1;
      score_req_q.push_back(w);
    end
  endtask

  initial begin
    logic [63:0] v;
    v = floor_sqrt(64'h8000_0000_0000_0000);
    for (int j = 0; j < dpst_pkg::FRAC_TABLE_BITS; j++) begin
      root_factor[j] = v[31:0];
      v = floor_sqrt(v << 32);
    end
    for (int i = 0; i < dpst_pkg::PEER_COUNT; i++) begin
      shadow_score[i] = '0;
      peer_touch[i] = '0;
      peer_known[i] = 1'b0;
    end
    rate_reg = dpst_pkg::DECAY_RATE_RESET;
    prune_thr = dpst_pkg::PRUNE_THRESHOLD_RESET;
    fwd_thr = dpst_pkg::FORWARD_THRESHOLD_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner cases at reset settings
    push_word(dpst_pkg::CMD_QUERY, 6'd0, '0, '0);              // unknown peer
    push_word(dpst_pkg::CMD_PENALIZE, 6'd1, '0, '0);           // unknown peer, zero penalty
    push_word(dpst_pkg::CMD_REWARD, 6'd2, '1, 32'd100);        // amount above 1.0
    push_word(dpst_pkg::CMD_REWARD, 6'd2, 17'd1000, 32'd100);  // saturates again
    push_word(dpst_pkg::CMD_LOAD, 6'd63, dpst_pkg::SCORE_ONE, 32'd1000);
    push_word(dpst_pkg::CMD_QUERY, 6'd63, '0, 32'd1000);       // no elapsed time
    push_word(dpst_pkg::CMD_QUERY, 6'd63, '0, 32'd999);        // time runs backwards
    push_word(dpst_pkg::CMD_QUERY, 6'd63, '0, 32'd4600);       // 3600 time units of decay
    push_word(dpst_pkg::CMD_REWARD, 6'd63, '0, 32'd4600);
    push_word(dpst_pkg::CMD_PENALIZE, 6'd63, 17'd10000, 32'd4600);
    push_word(dpst_pkg::CMD_REWARD, 6'd63, 17'd5, 32'd10);     // earlier touch time stored
    push_word(dpst_pkg::CMD_QUERY, 6'd63, '0, '1);             // decays to nothing
    push_word(dpst_pkg::CMD_PENALIZE, 6'd63, '1, '1);          // floors at zero
    push_word(dpst_pkg::CMD_LOAD, 6'd4, 17'd26214, 32'd50);    // exactly at forward threshold
    push_word(dpst_pkg::CMD_QUERY, 6'd4, '0, 32'd50);
    push_word(dpst_pkg::CMD_LOAD, 6'd4, 17'd26215, 32'd50);    // one above it
    push_word(dpst_pkg::CMD_QUERY, 6'd4, '0, 32'd50);
    push_word(dpst_pkg::CMD_LOAD, 6'd6, 17'd19761, 32'd7);
    push_word(dpst_pkg::CMD_PENALIZE, 6'd6, 17'd100, 32'd7);   // lands on prune threshold
    push_word(dpst_pkg::CMD_PENALIZE, 6'd6, 17'd1, 32'd7);     // just below it
    push_word(dpst_pkg::CMD_LOAD, 6'd7, '1, '1);               // load saturates
    push_word(dpst_pkg::CMD_LOAD, 6'd8, '0, '0);
    push_word(dpst_pkg::CMD_QUERY, 6'd8, '0, '0);              // known but zero score
    push_word(dpst_pkg::CMD_QUERY, 6'd3, '0, 32'd123);
    drain();

    // No decay, thresholds at the extremes
    program_regs('0, '0, dpst_pkg::SCORE_ONE);
    queue_random(220);
    drain();

    // Fastest decay, thresholds flipped
    program_regs('1, dpst_pkg::SCORE_ONE, '0);
    queue_random(220);
    drain();

    // Random settings, time wraps around
    program_regs(dpst_pkg::RATE_W'($urandom_range(3000000)),
                 dpst_pkg::SCORE_W'($urandom_range(65536)),
                 dpst_pkg::SCORE_W'($urandom_range(65536)));
    t_now = 32'hFFFF_F000;
    queue_random(230);
    drain();

    // Back to reset values: a stretch with no idling, then a long response hold-off
    program_regs(dpst_pkg::DECAY_RATE_RESET, dpst_pkg::PRUNE_THRESHOLD_RESET,
                 dpst_pkg::FORWARD_THRESHOLD_RESET);
    gap_pct = 0;
    queue_random(120);
    drain();
    gap_pct = 29;
    queue_random(120);
    hold_asked++;
    drain();

    failures += expected_scores.size();
    $display("covered %0d request words: reward %0d, penalize %0d, query %0d, load %0d",
             words_taken, cmd_hits[dpst_pkg::CMD_REWARD], cmd_hits[dpst_pkg::CMD_PENALIZE],
             cmd_hits[dpst_pkg::CMD_QUERY], cmd_hits[dpst_pkg::CMD_LOAD]);
    $display("%0d response words checked over %0d register writes, %0d failures",
             rsp_checked, cfg_writes, failures);
    if (failures == 0) begin
      $display("decaying_peer_score_table verification clean");
    end else begin
      $display("decaying_peer_score_table verification failed");
    end
    $finish;
  end

endmodule
